[hw/rtl/hashed_key_insert_lookup_table_defines.svh]
// ----------------------------------------------------------------------------
// hashed_key_insert_lookup_table_defines
// Assertion macros used by the lookup table back end (hkt_back).
// ----------------------------------------------------------------------------
`ifndef HASHED_KEY_INSERT_LOOKUP_TABLE_DEFINES_SVH
`define HASHED_KEY_INSERT_LOOKUP_TABLE_DEFINES_SVH
// Implication checked on every clock edge outside reset
`define HK_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
// Next-cycle implication outside reset
`define HK_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

[hw/rtl/hkt_pkg.sv]
// ----------------------------------------------------------------------------
// hkt_pkg
// Types and constants for the hashed key lookup table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package hkt_pkg;
  localparam int unsigned DefCapacity = 4096;
  localparam logic [63:0] HashSeed    = 64'd5381;
  localparam logic [5:0]  NameCntMax  = 6'd63;

  localparam logic [1:0] CfgEntryLimit  = 2'd0;
  localparam logic [1:0] CfgMaxNameLen  = 2'd1;
  localparam logic [1:0] CfgMaxValueLen = 2'd2;

  typedef enum logic [2:0] {
    StFound     = 3'd0,
    StNotFound  = 3'd1,
    StInserted  = 3'd2,
    StDuplicate = 3'd3,
    StFull      = 3'd4,
    StTooLong   = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    BkIdle,
    BkScan,
    BkRead,
    BkDone
  } back_state_e;

  // finished name, queued from front to back end
  typedef struct packed {
    logic        kind;
    logic [63:0] hash;
    logic [5:0]  name_cnt;
    logic [15:0] handle;
    logic [15:0] vlen;
  } job_t;
endpackage

[hw/rtl/hashed_key_insert_lookup_table.sv]
// ----------------------------------------------------------------------------
// hashed_key_insert_lookup_table
// djb2-keyed table with streamed name hashing, lookup and insert.
// ----------------------------------------------------------------------------
// Usage: drive one name byte per word with start; a word is taken when
// start is high and busy is low. Bytes hash one per cycle while busy is
// low. The word with last_i ends the name and queues a lookup or insert
// (kind_i) for the back end, which scans the hash store one entry per
// cycle through its RAM port. The final word's result appears on
// res_valid_o once the back end has scanned (sooner on a hit), for one
// cycle only; the receiver cannot stall. busy is high while
// a finished name is queued or in the back end, so bytes of the next name
// are taken from the cycle of the previous result on. Configuration words on
// cfg_valid_i / cfg_ready_o (index 0 entry_limit, 1 max_name_len,
// 2 max_value_len) are always taken.
// Reset empties the table (entry count 0), sets the hash seed and restores
// register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module hashed_key_insert_lookup_table import hkt_pkg::*; #(
  parameter int unsigned Capacity = DefCapacity
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        kind_i,
  input  logic [7:0]  name_byte_i,
  input  logic        has_byte_i,
  input  logic        last_i,
  input  logic [15:0] value_handle_i,
  input  logic [15:0] value_len_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output logic        res_valid_o,
  output logic [2:0]  status_o,
  output logic [15:0] value_out_o,
  output logic [63:0] key_hash_o
);
  logic [12:0] entry_limit_q;
  logic [5:0]  max_name_len_q;
  logic [15:0] max_value_len_q;
  logic        take, fj_valid, q_full, bj_valid, bj_ready, back_busy;
  job_t        fj, bj;

  assign take        = start && !busy;
  assign back_busy   = !bj_ready;
  assign busy        = q_full || back_busy;
  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_limit_q   <= 13'd4096;
      max_name_len_q  <= 6'd32;
      max_value_len_q <= 16'd2048;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgEntryLimit:  entry_limit_q   <= cfg_data_i[12:0];
        CfgMaxNameLen:  max_name_len_q  <= cfg_data_i[5:0];
        CfgMaxValueLen: max_value_len_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  hkt_front u_front (
    .clk_i, .rst_ni, .take_i(take), .kind_i, .name_byte_i, .has_byte_i, .last_i,
    .value_handle_i, .value_len_i, .job_valid_o(fj_valid), .job_o(fj));

  hkt_queue u_queue (
    .clk_i, .rst_ni, .in_valid_i(fj_valid), .in_job_i(fj), .full_o(q_full),
    .out_valid_o(bj_valid), .out_job_o(bj), .out_ready_i(bj_ready));

  hkt_back #(.Capacity(Capacity)) u_back (
    .clk_i, .rst_ni, .job_valid_i(bj_valid), .job_i(bj), .job_ready_o(bj_ready),
    .entry_limit_i(entry_limit_q), .max_name_len_i(max_name_len_q),
    .max_value_len_i(max_value_len_q), .res_valid_o, .status_o, .value_out_o,
    .key_hash_o);
endmodule

[hw/rtl/hkt_ram.sv]
// ----------------------------------------------------------------------------
// hkt_ram
// Generic single-port write, single-port read RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module hkt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[hw/rtl/hkt_front.sv]
// ----------------------------------------------------------------------------
// hkt_front
// Hashes name bytes one per cycle while take_i is high; on the last byte queues a job.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module hkt_front import hkt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        take_i,
  input  logic        kind_i,
  input  logic [7:0]  name_byte_i,
  input  logic        has_byte_i,
  input  logic        last_i,
  input  logic [15:0] value_handle_i,
  input  logic [15:0] value_len_i,
  output logic        job_valid_o,
  output job_t        job_o
);
  logic [63:0] hash_q, hash_d, upd;
  logic [5:0]  cnt_q, cnt_d, cnt_upd;

  // hash*33 + byte
  assign upd     = has_byte_i ? ({hash_q[58:0], 5'd0} + hash_q + {56'd0, name_byte_i})
                              : hash_q;
  assign cnt_upd = (has_byte_i && cnt_q != NameCntMax) ? cnt_q + 6'd1 : cnt_q;

  always_comb begin
    hash_d = hash_q;
    cnt_d  = cnt_q;
    if (take_i) begin
      hash_d = last_i ? HashSeed : upd;
      cnt_d  = last_i ? 6'd0 : cnt_upd;
    end
  end

  assign job_valid_o   = take_i && last_i;
  assign job_o.kind     = kind_i;
  assign job_o.hash     = (cnt_upd == 6'd0) ? 64'd0 : ({upd[58:0], 5'd0} + upd);
  assign job_o.name_cnt = cnt_upd;
  assign job_o.handle   = value_handle_i;
  assign job_o.vlen     = value_len_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= HashSeed;
      cnt_q  <= 6'd0;
    end else begin
      hash_q <= hash_d;
      cnt_q  <= cnt_d;
    end
  end
endmodule

[hw/rtl/hkt_back.sv]
// ----------------------------------------------------------------------------
// hkt_back
// Scans the hash store for a job's key, then looks up or inserts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "hashed_key_insert_lookup_table_defines.svh"
module hkt_back import hkt_pkg::*; #(
  parameter int unsigned Capacity = DefCapacity
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        job_valid_i,
  input  job_t        job_i,
  output logic        job_ready_o,
  input  logic [12:0] entry_limit_i,
  input  logic [5:0]  max_name_len_i,
  input  logic [15:0] max_value_len_i,
  output logic        res_valid_o,
  output logic [2:0]  status_o,
  output logic [15:0] value_out_o,
  output logic [63:0] key_hash_o
);
  localparam int unsigned AW = $clog2(Capacity);
  localparam int unsigned CW = $clog2(Capacity + 1);

  back_state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          rd_pend_q, rd_pend_d;
  logic          hit_q, hit_d;
  logic [AW-1:0] hit_idx_q, hit_idx_d;
  job_t          job_q;
  logic          job_load;
  logic [63:0]   hash_rd;
  logic [15:0]   val_rd;
  logic [AW-1:0] hash_raddr, val_raddr, rd_addr_q;
  logic          we;
  logic [2:0]    status_q, status_d;
  logic [15:0]   vout_q, vout_d;
  logic          res_q, res_d;
  logic [31:0]   lim_ext;
  logic [CW-1:0] cap_lim;
  logic          match;

  // entry limit clipped to the table size
  assign lim_ext = {19'd0, entry_limit_i};
  assign cap_lim = (lim_ext > Capacity) ? CW'(Capacity) : CW'(lim_ext);

  hkt_ram #(.Width(64), .Depth(Capacity)) u_hash_ram (
    .clk_i(clk_i), .we_i(we), .waddr_i(count_q[AW-1:0]), .wdata_i(job_q.hash),
    .raddr_i(hash_raddr), .rdata_o(hash_rd));
  hkt_ram #(.Width(16), .Depth(Capacity)) u_val_ram (
    .clk_i(clk_i), .we_i(we), .waddr_i(count_q[AW-1:0]), .wdata_i(job_q.handle),
    .raddr_i(val_raddr), .rdata_o(val_rd));

  assign hash_raddr = idx_q[AW-1:0];
  assign val_raddr  = hit_idx_q;
  assign job_ready_o = (state_q == BkIdle);
  assign job_load    = job_ready_o && job_valid_i;
  assign match       = rd_pend_q && (hash_rd == job_q.hash);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BkIdle:  if (job_valid_i) state_d = BkScan;
      BkScan:  if (match || (!rd_pend_q && idx_q >= count_q)) state_d = BkRead;
      BkRead:  state_d = BkDone;
      BkDone:  state_d = BkIdle;
      default: state_d = BkIdle;
    endcase
  end

  // datapath and outputs
  always_comb begin
    idx_d     = idx_q;
    rd_pend_d = 1'b0;
    hit_d     = hit_q;
    hit_idx_d = hit_idx_q;
    count_d   = count_q;
    status_d  = status_q;
    vout_d    = 16'd0;
    res_d     = 1'b0;
    we        = 1'b0;
    case (state_q)
      BkIdle: begin
        idx_d = '0;
        hit_d = 1'b0;
      end
      BkScan: begin
        if (match) begin
          hit_d     = 1'b1;
          hit_idx_d = rd_addr_q;
        end else if (idx_q < count_q) begin
          rd_pend_d = 1'b1;
          idx_d     = idx_q + CW'(1);
        end
      end
      BkRead: begin
        if (job_q.kind == 1'b0) begin
          status_d = hit_q ? StFound : StNotFound;
        end else if (hit_q) begin
          status_d = StDuplicate;
        end else if (count_q >= cap_lim) begin
          status_d = StFull;
        end else if (job_q.vlen >= max_value_len_i || job_q.name_cnt >= max_name_len_i) begin
          status_d = StTooLong;
        end else begin
          status_d = StInserted;
          we       = 1'b1;
          count_d  = count_q + CW'(1);
        end
      end
      BkDone: begin
        res_d  = 1'b1;
        vout_d = (status_q == StFound) ? val_rd : 16'd0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BkIdle;
      count_q   <= '0;
      idx_q     <= '0;
      rd_pend_q <= 1'b0;
      hit_q     <= 1'b0;
      res_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      idx_q     <= idx_d;
      rd_pend_q <= rd_pend_d;
      hit_q     <= hit_d;
      res_q     <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_load) job_q <= job_i;
    rd_addr_q <= hash_raddr;
    hit_idx_q <= hit_idx_d;
    status_q  <= status_d;
    vout_q    <= vout_d;
  end

  assign res_valid_o = res_q;
  assign status_o    = status_q;
  assign value_out_o = vout_q;
  assign key_hash_o  = job_q.hash;

  `HK_ASSERT_IMP(a_count_cap, clk_i, rst_ni, 1'b1, count_q <= CW'(Capacity))
  `HK_ASSERT_NEXT(a_res_after_done, clk_i, rst_ni, state_q == BkDone, res_q)
  `HK_ASSERT_IMP(a_res_only_idle, clk_i, rst_ni, res_q, state_q == BkIdle)
endmodule

[hw/rtl/hkt_queue.sv]
// ----------------------------------------------------------------------------
// hkt_queue
// Two-entry job queue between the hashing front end and the table back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module hkt_queue import hkt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  job_t in_job_i,
  output logic full_o,
  output logic out_valid_o,
  output job_t out_job_o,
  input  logic out_ready_i
);
  job_t       slot_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign push        = in_valid_i && (cnt_q != 2'd2);
  assign pop         = out_ready_i && (cnt_q != 2'd0);
  assign full_o      = (cnt_q != 2'd0);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_job_o   = slot_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wp_q] <= in_job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
